### src/c2i_pkg.sv
// c2i_pkg: shared types, codes and default sizes of the col2im scatter-accumulate block
// no dependencies; used by the other modules of the block by scoped names, but not by c2i_ram
package c2i_pkg;

   // default sizes, handed to the top level parameters
   localparam int unsigned MAX_SIDE_DEF   = 64;
   localparam int unsigned MAX_KERNEL_DEF = 16;
   localparam int unsigned MAX_BLOCKS_DEF = 64;

   // fixed field widths
   localparam int unsigned VAL_W      = 16;
   localparam int unsigned PIX_W      = 25;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // item kinds
   localparam logic KIND_ACC  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_IMAGE_HEIGHT  = 3'd0,
      CFG_IMAGE_WIDTH   = 3'd1,
      CFG_KERNEL_HEIGHT = 3'd2,
      CFG_KERNEL_WIDTH  = 3'd3,
      CFG_BLOCK_ROWS    = 3'd4,
      CFG_BLOCK_COLS    = 3'd5,
      CFG_STEP_PAIRS    = 3'd6,
      CFG_PAD_PAIRS     = 3'd7
   } cfg_index_type;

   // input beat
   typedef struct packed {
      logic                    kind;
      logic signed [VAL_W-1:0] col_value;
   } req_type;

   // result beat
   typedef struct packed {
      logic signed [PIX_W-1:0] pixel_value;
      logic                    last_pixel;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic clear_wr;
      logic latch;
      logic calc_pos;
      logic calc_addr;
      logic rd_acc;
      logic wr_acc;
      logic rd_out;
      logic wr_out;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic clear_last;
      logic slot_free;
   } sts_type;

endpackage

### src/c2i_ram.sv
// c2i_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module c2i_ram #(
   parameter int unsigned WIDTH = 25,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/c2i_ctrl.sv
// c2i_ctrl: sequencer of the col2im block: clearing pass, accumulate and readout steps
// depends on c2i_pkg (command and status structs, item kinds)
module c2i_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_kind,
   output logic             req_ready,
   output c2i_pkg::cmd_type cmd,
   input  c2i_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_POS,
      S_ADDR,
      S_ACC_RD,
      S_ACC_WR,
      S_OUT_RD,
      S_OUT_WR
   } state_type;

   state_type state_ff, state_in;
   logic      ready_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      ready_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            ready_in = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = (req_kind == c2i_pkg::KIND_READ) ? S_OUT_RD : S_POS;
            end
         end
         S_POS: begin
            cmd.calc_pos = 1'b1;
            state_in     = S_ADDR;
         end
         S_ADDR: begin
            cmd.calc_addr = 1'b1;
            state_in      = S_ACC_RD;
         end
         S_ACC_RD: begin
            cmd.rd_acc = 1'b1;
            state_in   = S_ACC_WR;
         end
         S_ACC_WR: begin
            cmd.wr_acc = 1'b1;
            state_in   = S_IDLE;
         end
         S_OUT_RD: begin
            cmd.rd_out = 1'b1;
            state_in   = S_OUT_WR;
         end
         S_OUT_WR: begin
            // hold the read data until the result register can take it
            if (sts.slot_free) begin
               cmd.wr_out = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = ready_in;

endmodule

### src/c2i_dp.sv
// c2i_dp: datapath of the col2im block: config registers, position counters,
// address arithmetic, image store and result register
// depends on c2i_pkg and c2i_ram
module c2i_dp #(
   parameter int unsigned MAX_SIDE   = c2i_pkg::MAX_SIDE_DEF,
   parameter int unsigned MAX_KERNEL = c2i_pkg::MAX_KERNEL_DEF,
   parameter int unsigned MAX_BLOCKS = c2i_pkg::MAX_BLOCKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [c2i_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [c2i_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   input  c2i_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output c2i_pkg::rsp_type                  rsp_data,
   input  c2i_pkg::cmd_type                  cmd,
   output c2i_pkg::sts_type                  sts
);

   localparam int unsigned DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int unsigned LIN_W  = 2 * SIDE_W;
   localparam int unsigned KER_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int unsigned BLK_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned KLIM_W = $clog2(MAX_KERNEL + 1);
   localparam int unsigned BLIM_W = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned CNT_W  = (BLK_W > KER_W) ? BLK_W : KER_W;
   localparam int unsigned POS_W  = ((CNT_W + 5 > 8) ? CNT_W + 5 : 8) + 1;
   localparam int unsigned PIX_W  = c2i_pkg::PIX_W;

   // size register: zero acts as one, above the limit acts as the limit
   function automatic logic [8:0] clamp_size(input logic [6:0] v, input int unsigned max_v);
      logic [8:0] r;
      if (v == 7'd0) begin
         r = 9'd1;
      end else if (32'(v) > max_v) begin
         r = 9'(max_v);
      end else begin
         r = {2'b00, v};
      end
      return r;
   endfunction

   // stride or dilation nibble: zero acts as one
   function automatic logic [3:0] nib(input logic [3:0] n);
      return (n == 4'd0) ? 4'd1 : n;
   endfunction

   // configuration registers
   logic [6:0]  cfg_ih_ff, cfg_iw_ff, cfg_br_ff, cfg_bc_ff;
   logic [4:0]  cfg_kh_ff, cfg_kw_ff;
   logic [15:0] cfg_step_ff, cfg_pad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ih_ff   <= 7'd1;
         cfg_iw_ff   <= 7'd1;
         cfg_kh_ff   <= 5'd1;
         cfg_kw_ff   <= 5'd1;
         cfg_br_ff   <= 7'd1;
         cfg_bc_ff   <= 7'd1;
         cfg_step_ff <= 16'h1111;
         cfg_pad_ff  <= 16'h0000;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            c2i_pkg::CFG_IMAGE_HEIGHT:  cfg_ih_ff   <= csr_wr_data[6:0];
            c2i_pkg::CFG_IMAGE_WIDTH:   cfg_iw_ff   <= csr_wr_data[6:0];
            c2i_pkg::CFG_KERNEL_HEIGHT: cfg_kh_ff   <= csr_wr_data[4:0];
            c2i_pkg::CFG_KERNEL_WIDTH:  cfg_kw_ff   <= csr_wr_data[4:0];
            c2i_pkg::CFG_BLOCK_ROWS:    cfg_br_ff   <= csr_wr_data[6:0];
            c2i_pkg::CFG_BLOCK_COLS:    cfg_bc_ff   <= csr_wr_data[6:0];
            c2i_pkg::CFG_STEP_PAIRS:    cfg_step_ff <= csr_wr_data;
            c2i_pkg::CFG_PAD_PAIRS:     cfg_pad_ff  <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // effective sizes and steps
   logic [SIDE_W-1:0] ih_eff, iw_eff;
   logic [KLIM_W-1:0] kh_eff, kw_eff;
   logic [BLIM_W-1:0] br_eff, bc_eff;
   logic [3:0]        sh, sw, dh, dw;

   assign ih_eff = SIDE_W'(clamp_size(cfg_ih_ff, MAX_SIDE));
   assign iw_eff = SIDE_W'(clamp_size(cfg_iw_ff, MAX_SIDE));
   assign kh_eff = KLIM_W'(clamp_size({2'b00, cfg_kh_ff}, MAX_KERNEL));
   assign kw_eff = KLIM_W'(clamp_size({2'b00, cfg_kw_ff}, MAX_KERNEL));
   assign br_eff = BLIM_W'(clamp_size(cfg_br_ff, MAX_BLOCKS));
   assign bc_eff = BLIM_W'(clamp_size(cfg_bc_ff, MAX_BLOCKS));
   assign sh     = nib(cfg_step_ff[15:12]);
   assign sw     = nib(cfg_step_ff[11:8]);
   assign dh     = nib(cfg_step_ff[7:4]);
   assign dw     = nib(cfg_step_ff[3:0]);

   // pixel count of the image, refreshed every cycle
   logic [LIN_W-1:0] total_ff;

   always_ff @(posedge clock) begin
      total_ff <= LIN_W'(ih_eff) * LIN_W'(iw_eff);
   end

   // latched column value
   logic signed [c2i_pkg::VAL_W-1:0] val_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         val_ff <= req_data.col_value;
      end
   end

   // kernel and block position counters, block column fastest
   logic [KER_W-1:0] krow_ff, kcol_ff;
   logic [BLK_W-1:0] brow_ff, bcol_ff;
   logic             bcol_wrap, brow_wrap, kcol_wrap, krow_wrap;

   assign bcol_wrap = ({1'b0, bcol_ff} + 1'b1) >= bc_eff;
   assign brow_wrap = ({1'b0, brow_ff} + 1'b1) >= br_eff;
   assign kcol_wrap = ({1'b0, kcol_ff} + 1'b1) >= kw_eff;
   assign krow_wrap = ({1'b0, krow_ff} + 1'b1) >= kh_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bcol_ff <= '0;
         brow_ff <= '0;
         kcol_ff <= '0;
         krow_ff <= '0;
      end else if (cmd.calc_pos) begin
         bcol_ff <= bcol_wrap ? '0 : bcol_ff + 1'b1;
         if (bcol_wrap) begin
            brow_ff <= brow_wrap ? '0 : brow_ff + 1'b1;
            if (brow_wrap) begin
               kcol_ff <= kcol_wrap ? '0 : kcol_ff + 1'b1;
               if (kcol_wrap) begin
                  krow_ff <= krow_wrap ? '0 : krow_ff + 1'b1;
               end
            end
         end
      end
   end

   // image row and column of the current value, two's complement
   logic [POS_W-1:0] row_ff, col_ff, row_in, col_in;

   assign row_in = POS_W'(brow_ff) * POS_W'(sh) + POS_W'(krow_ff) * POS_W'(dh)
                   - POS_W'(cfg_pad_ff[15:8]);
   assign col_in = POS_W'(bcol_ff) * POS_W'(sw) + POS_W'(kcol_ff) * POS_W'(dw)
                   - POS_W'(cfg_pad_ff[7:0]);

   always_ff @(posedge clock) begin
      if (cmd.calc_pos) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // bounds check and linear address
   logic              in_range_ff, in_range_in;
   logic [LIN_W-1:0]  lin_in;
   logic [ADDR_W-1:0] addr_ff;

   assign in_range_in = !row_ff[POS_W-1] && (row_ff < POS_W'(ih_eff)) &&
                        !col_ff[POS_W-1] && (col_ff < POS_W'(iw_eff));
   assign lin_in      = LIN_W'(row_ff[SIDE_W-1:0]) * LIN_W'(iw_eff)
                        + LIN_W'(col_ff[SIDE_W-1:0]);

   // readout position, restarted when it lies beyond the image
   logic [ADDR_W-1:0] readout_ff, out_pos;
   logic              last_ff;

   assign out_pos = (LIN_W'(readout_ff) >= total_ff) ? '0 : readout_ff;

   always_ff @(posedge clock) begin
      if (cmd.calc_addr) begin
         in_range_ff <= in_range_in;
         addr_ff     <= lin_in[ADDR_W-1:0];
      end else if (cmd.rd_out) begin
         addr_ff <= out_pos;
         last_ff <= (LIN_W'(out_pos) == total_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         readout_ff <= '0;
      end else if (cmd.wr_out) begin
         readout_ff <= last_ff ? '0 : addr_ff + 1'b1;
      end
   end

   // clearing pass counter
   logic [ADDR_W-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // image store ports
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [PIX_W-1:0]  ram_wr_data, ram_rd_data, acc_sum;

   assign acc_sum = ram_rd_data + PIX_W'(val_ff);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = '0;
      if (cmd.clear_wr) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
      end else if (cmd.wr_acc) begin
         ram_wr_en   = in_range_ff;
         ram_wr_data = acc_sum;
      end else if (cmd.wr_out) begin
         ram_wr_en   = 1'b1;
      end
   end

   assign ram_rd_en   = cmd.rd_acc || cmd.rd_out;
   assign ram_rd_addr = cmd.rd_out ? out_pos : addr_ff;

   c2i_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result register
   logic             rsp_valid_ff;
   c2i_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.wr_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_out) begin
         rsp_data_ff.pixel_value <= ram_rd_data;
         rsp_data_ff.last_pixel  <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_data_ff;
   assign sts.slot_free  = !rsp_valid_ff || rsp_ready;
   assign sts.clear_last = (clr_ff == ADDR_W'(DEPTH - 1));

endmodule

### src/col2im_scatter_accumulate.sv
// col2im_scatter_accumulate: top level of the two-dimensional col2im block
// depends on c2i_pkg, c2i_ctrl, c2i_dp (and c2i_ram below it)
//
// Usage
//   req_* carries one beat per item: kind 0 adds col_value (Q8.8) into the
//   image pixel that the tracked kernel and block positions address, kind 1
//   reads the next pixel in row-major order, clears it and flags the last.
//   rsp_* returns one beat for each read item and none for an accumulate.
//   csr_* writes the eight configuration registers, one per cycle, no wait;
//   write only while the block is idle.
// Sequencing
//   Items are handled one at a time. An accumulate passes, from accept to the
//   next accept, through position multiply, address multiply, store read and
//   store write-back, each a state of the sequencer. A read passes through a
//   store read and a result write, which waits until the result register is
//   free and then loads it from the registered read data of the image store.
// Reset and stall
//   After reset the image store is cleared in a pass over all MAX_SIDE*MAX_SIDE
//   addresses (4096 by default) with req_ready low; csr writes are taken as ever.
//   The result register holds while rsp_ready is low; a further accumulate is
//   still taken, and a further read waits until the register frees up.
module col2im_scatter_accumulate #(
   parameter int unsigned MAX_SIDE   = c2i_pkg::MAX_SIDE_DEF,
   parameter int unsigned MAX_KERNEL = c2i_pkg::MAX_KERNEL_DEF,
   parameter int unsigned MAX_BLOCKS = c2i_pkg::MAX_BLOCKS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [c2i_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [c2i_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  c2i_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output c2i_pkg::rsp_type               rsp_data
);

   c2i_pkg::cmd_type cmd;
   c2i_pkg::sts_type sts;

   // sequencer
   c2i_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath with the image store
   c2i_dp #(
      .MAX_SIDE   (MAX_SIDE),
      .MAX_KERNEL (MAX_KERNEL),
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

### src/c2i_checker.sv
// c2i_checker: port-level assertions for col2im_scatter_accumulate, bound to the top level
// depends on c2i_pkg and col2im_scatter_accumulate
module c2i_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input c2i_pkg::req_type               req_data,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input c2i_pkg::rsp_type               rsp_data
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // reset starts the clearing pass with nothing offered
   assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block not quiet after reset");

   // one item at a time: no accept in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while previous item still in work");

   // an accumulate never produces a result beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.kind == c2i_pkg::KIND_ACC)
      |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("result beat after an accumulate");

endmodule

bind col2im_scatter_accumulate c2i_checker u_checker (.*);
